FILE: hdl/amsgu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amsgu_pkg
// Shared constants of the AMSGrad update core: widths, register indexes,
// register reset values and stream packing.
// ----------------------------------------------------------------------------
package amsgu_pkg;

  // table depth default
  localparam int NumParamsDef = 32;

  // field widths
  localparam int IdxRawW = 5;
  localparam int ValW    = 32;
  localparam int CfgW    = 24;
  localparam int CfgIdxW = 2;

  // stream data widths, padded to whole bytes
  localparam int InTdataW  = 40;
  localparam int OutTdataW = 40;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_STEP_SIZE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BETA_FIRST  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BETA_SECOND = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_EPSILON     = 2'd3;

  // register reset values
  localparam logic [23:0] STEP_SIZE_RST   = 24'd503316;
  localparam logic [23:0] BETA_FIRST_RST  = 24'd15099494;
  localparam logic [23:0] BETA_SECOND_RST = 24'd16760438;
  localparam logic [15:0] EPSILON_RST     = 16'd1;

endpackage
`default_nettype wire

FILE: hdl/amsgrad_parameter_update_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amsgrad_parameter_update_core
// Per-entry AMSGrad update engine in fixed point, state kept in two RAMs.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output buffer has room and the
// interlock allows, and returns one result per request, in order. Each
// request passes through moment arithmetic, a one-bit-per-stage square
// root, the denominator and a one-bit-per-stage divider. Moments are written
// back to the moment RAM from the third stage, the parameter from the last
// stage. A request addressing an entry still in the pipeline waits (tready
// low) until that entry has been written back, so requests to distinct
// entries run at one per cycle while the buffer has room, while repeated
// updates of one entry each wait for the one before. A two-entry output
// buffer keeps the pipeline moving while a result waits; the pipeline stalls while both entries are full.
// ----------------------------------------------------------------------------
module amsgrad_parameter_update_core
  import amsgu_pkg::*;
#(
  parameter int NUM_PARAMS = NumParamsDef
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // configuration write port
  input  wire                  cfg_we_i,
  input  wire [CfgIdxW-1:0]    cfg_idx_i,
  input  wire [CfgW-1:0]       cfg_data_i,
  // request stream
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire [InTdataW-1:0]   s_axis_tdata,  // entry_index[4:0], operand_value[36:5]
  input  wire                  s_axis_tuser,  // command[0]
  // result stream
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,  // result_index[4:0], param_value[36:5]
  output logic                 m_axis_tuser   // saturated[0]
);

  localparam int IdxW      = $clog2(NUM_PARAMS);
  localparam int SqSteps   = 32;
  localparam int DivSteps  = 57;
  localparam int Stages    = 4 + SqSteps + 1 + DivSteps;
  localparam int Last      = Stages - 1;
  localparam int MomW      = 160;

  typedef struct packed {
    logic                cmd;
    logic [IdxRawW-1:0]  idx_raw;
    logic [IdxW-1:0]     idx;
    logic [ValW-1:0]     p;
    logic                sat;
    logic                mneg;
  } side_t;

  // raw index to table entry, modulo the table depth
  function automatic logic [31:0][IdxW-1:0] build_idx_lut();
    logic [31:0][IdxW-1:0] lut;
    int r;
    for (int i = 0; i < 32; i++) begin
      r = i;
      for (int k = 0; k < 32; k++) begin
        if (r >= NUM_PARAMS) r = r - NUM_PARAMS;
      end
      lut[i] = IdxW'(r);
    end
    return lut;
  endfunction

  localparam logic [31:0][IdxW-1:0] IDX_LUT = build_idx_lut();

  // configuration registers
  logic [23:0] step_q, b1_q, b2_q;
  logic [15:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_SIZE_RST;
      b1_q   <= BETA_FIRST_RST;
      b2_q   <= BETA_SECOND_RST;
      eps_q  <= EPSILON_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_SIZE:   step_q <= cfg_data_i;
        CFG_BETA_FIRST:  b1_q   <= cfg_data_i;
        CFG_BETA_SECOND: b2_q   <= cfg_data_i;
        CFG_EPSILON:     eps_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [1:0]       ocnt_q;
  logic             en;
  logic             in_acc;
  logic             hazard;
  logic [IdxW-1:0]  in_idx;
  logic [Stages-1:0] vld_q;
  side_t            side_q  [Stages];
  side_t            side_nx [Stages];
  side_t            side_in;

  assign en     = (ocnt_q != 2'd2);
  assign in_idx = IDX_LUT[s_axis_tdata[4:0]];

  // interlock: entry still in flight
  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < Stages; k++) begin
      if (vld_q[k] && (side_q[k].idx == in_idx)) hazard = 1'b1;
    end
  end

  assign s_axis_tready = en && !hazard;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    side_in         = '0;
    side_in.cmd     = s_axis_tuser;
    side_in.idx_raw = s_axis_tdata[4:0];
    side_in.idx     = in_idx;
  end

  // state memories
  logic [MomW-1:0] mom_rdata, mom_wdata;
  logic            mom_we;
  logic [ValW-1:0] prm_rdata, res_p;
  logic            push;

  amsgu_ram #(.Width(MomW), .Depth(NUM_PARAMS)) u_mom_ram (
    .clk_i   (clk_i),
    .we_i    (mom_we),
    .waddr_i (side_q[2].idx),
    .wdata_i (mom_wdata),
    .re_i    (in_acc),
    .raddr_i (in_idx),
    .rdata_o (mom_rdata)
  );

  amsgu_ram #(.Width(ValW), .Depth(NUM_PARAMS)) u_prm_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (side_q[Last].idx),
    .wdata_i (res_p),
    .re_i    (in_acc),
    .raddr_i (in_idx),
    .rdata_o (prm_rdata)
  );

  // stage 1: products from stored moments and the gradient
  logic signed [31:0] g1_q;
  logic signed [31:0] m1;
  logic [63:0]        v1, vmax1;
  logic [24:0]        omb1;
  logic [31:0]        gmag1;

  assign m1    = $signed(mom_rdata[31:0]);
  assign v1    = mom_rdata[95:32];
  assign vmax1 = mom_rdata[159:96];
  assign omb1  = 25'h100_0000 - {1'b0, b1_q};
  assign gmag1 = g1_q[31] ? 32'(-g1_q) : 32'(g1_q);

  logic signed [56:0] pm1_q;
  logic signed [57:0] pm2_q;
  logic [63:0]        g2_q, vmax2_q;
  logic [55:0]        pvl2_q, pvh2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_q    <= $signed(s_axis_tdata[36:5]);
      pm1_q   <= $signed({1'b0, b1_q}) * m1;
      pm2_q   <= $signed({1'b0, omb1}) * g1_q;
      g2_q    <= gmag1 * gmag1;
      pvl2_q  <= v1[31:0] * b2_q;
      pvh2_q  <= v1[63:32] * b2_q;
      vmax2_q <= vmax1;
    end
  end

  // stage 2: first moment, square-gradient products
  logic signed [59:0] msum2;
  logic signed [35:0] mfull2;
  logic               msat2;
  logic [31:0]        mq2;
  logic [24:0]        omb2;

  assign msum2  = 60'(pm1_q) + 60'(pm2_q) + 60'sh80_0000;
  assign mfull2 = 36'(msum2 >>> 24);
  assign omb2   = 25'h100_0000 - {1'b0, b2_q};

  always_comb begin
    msat2 = 1'b0;
    mq2   = mfull2[31:0];
    if (mfull2 > 36'sh0_7FFF_FFFF) begin
      msat2 = 1'b1;
      mq2   = 32'h7FFF_FFFF;
    end else if (mfull2 < -36'sh0_8000_0000) begin
      msat2 = 1'b1;
      mq2   = 32'h8000_0000;
    end
  end

  logic [31:0] mq3_q;
  logic        msat3_q;
  logic [55:0] pvl3_q, pvh3_q;
  logic [56:0] gl3_q, gh3_q;
  logic [63:0] vmax3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mq3_q   <= mq2;
      msat3_q <= msat2;
      pvl3_q  <= pvl2_q;
      pvh3_q  <= pvh2_q;
      gl3_q   <= g2_q[31:0] * omb2;
      gh3_q   <= g2_q[63:32] * omb2;
      vmax3_q <= vmax2_q;
    end
  end

  // stage 3: second moment, running max, numerator, moment write-back
  logic [57:0] lo3;
  logic [58:0] hi3;
  logic        vsat3;
  logic [63:0] v3, vm3;
  logic [31:0] mqmag3;

  assign lo3    = 58'(pvl3_q) + 58'(gl3_q) + 58'h80_0000;
  assign hi3    = 59'(pvh3_q) + 59'(gh3_q) + 59'(lo3[57:32]);
  assign vsat3  = |hi3[58:56];
  assign v3     = vsat3 ? '1 : {hi3[55:0], lo3[31:24]};
  assign vm3    = (v3 > vmax3_q) ? v3 : vmax3_q;
  assign mqmag3 = mq3_q[31] ? 32'(-$signed(mq3_q)) : mq3_q;

  assign mom_we    = en && vld_q[2];
  assign mom_wdata = side_q[2].cmd ? {vm3, v3, mq3_q} : '0;

  // side info updates along the way
  always_comb begin
    for (int k = 0; k < Stages; k++) side_nx[k] = side_q[k];
    side_nx[0].p    = side_q[0].cmd ? prm_rdata : g1_q;
    side_nx[2].sat  = side_q[2].cmd & (msat3_q | vsat3);
    side_nx[2].mneg = side_q[2].cmd & mq3_q[31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], in_acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k < Stages; k++) side_q[k] <= side_nx[k-1];
    end
  end

  // square root of the running max, one result bit per stage
  logic [63:0] sq_x_q    [SqSteps+1];
  logic [33:0] sq_rem_q  [SqSteps+1];
  logic [31:0] sq_root_q [SqSteps+1];
  logic [55:0] sq_num_q  [SqSteps+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_x_q[0]    <= vm3;
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_num_q[0]  <= step_q * mqmag3;
    end
  end

  for (genvar j = 0; j < SqSteps; j++) begin : g_sqrt
    logic [35:0] rs;
    logic [35:0] trial;
    logic        ge;
    assign rs    = {sq_rem_q[j], sq_x_q[j][63:62]};
    assign trial = {2'b00, sq_root_q[j], 2'b01};
    assign ge    = (rs >= trial);
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_x_q[j+1]    <= {sq_x_q[j][61:0], 2'b00};
        sq_rem_q[j+1]  <= ge ? 34'(rs - trial) : rs[33:0];
        sq_root_q[j+1] <= {sq_root_q[j][30:0], ge};
        sq_num_q[j+1]  <= sq_num_q[j];
      end
    end
  end

  // denominator and rounded dividend
  logic [32:0] dsum;
  logic [32:0] dval;

  assign dsum = {1'b0, sq_root_q[SqSteps]} + 33'(eps_q);
  assign dval = (dsum == '0) ? 33'd1 : dsum;

  logic [56:0] dv_n_q   [DivSteps+1];
  logic [40:0] dv_rem_q [DivSteps+1];
  logic [40:0] dv_den_q [DivSteps+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_n_q[0]   <= 57'(sq_num_q[SqSteps]) + 57'({dval, 7'b0});
      dv_rem_q[0] <= '0;
      dv_den_q[0] <= {dval, 8'b0};
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic [41:0] rs;
    logic        ge;
    assign rs = {dv_rem_q[j], dv_n_q[j][56]};
    assign ge = (rs >= {1'b0, dv_den_q[j]});
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_n_q[j+1]   <= {dv_n_q[j][55:0], ge};
        dv_rem_q[j+1] <= ge ? 41'(rs - {1'b0, dv_den_q[j]}) : rs[40:0];
        dv_den_q[j+1] <= dv_den_q[j];
      end
    end
  end

  // parameter step and saturation
  logic signed [58:0] pext, psum;
  logic               psat;
  side_t              sl;

  assign sl   = side_q[Last];
  assign pext = 59'($signed(sl.p));
  assign psum = sl.mneg ? pext + $signed({2'b00, dv_n_q[DivSteps]})
                        : pext - $signed({2'b00, dv_n_q[DivSteps]});

  always_comb begin
    psat  = 1'b0;
    res_p = psum[31:0];
    if (!sl.cmd) begin
      res_p = sl.p;
    end else if (psum > 59'sh7FFF_FFFF) begin
      psat  = 1'b1;
      res_p = 32'h7FFF_FFFF;
    end else if (psum < -59'sh8000_0000) begin
      psat  = 1'b1;
      res_p = 32'h8000_0000;
    end
  end

  assign push = en && vld_q[Last];

  // two-entry result buffer
  logic [IdxRawW-1:0] of_idx_q [2];
  logic [ValW-1:0]    of_p_q   [2];
  logic               of_sat_q [2];
  logic               wp_q, rp_q;
  logic               pop;

  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      ocnt_q <= ocnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      of_idx_q[wp_q] <= sl.idx_raw;
      of_p_q[wp_q]   <= res_p;
      of_sat_q[wp_q] <= sl.cmd & (sl.sat | psat);
    end
  end

  assign m_axis_tvalid = (ocnt_q != 2'd0);
  assign m_axis_tdata  = {3'b000, of_p_q[rp_q], of_idx_q[rp_q]};
  assign m_axis_tuser  = of_sat_q[rp_q];

endmodule
`default_nettype wire

FILE: hdl/amsgu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amsgu_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module amsgu_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire                     re_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/amsgu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amsgu_checker
// Port-level assertions for the AMSGrad update core, bound to the top level.
// ----------------------------------------------------------------------------
module amsgu_checker
  import amsgu_pkg::*;
(
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 s_axis_tvalid,
  input wire                 s_axis_tready,
  input wire [InTdataW-1:0]  s_axis_tdata,
  input wire                 m_axis_tvalid,
  input wire                 m_axis_tready,
  input wire [OutTdataW-1:0] m_axis_tdata,
  input wire                 m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

  // same entry cannot be taken twice in a row, it is still in flight
  a_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=>
      !(s_axis_tvalid && s_axis_tready &&
        (s_axis_tdata[4:0] == $past(s_axis_tdata[4:0]))))
    else $error("same entry accepted in consecutive cycles");

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result right after reset");

  // padding bits of the result stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutTdataW-1:37] == '0))
    else $error("result padding not zero");

endmodule

bind amsgrad_parameter_update_core amsgu_checker u_amsgu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
